/* hdl/bft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_pkg: shared types and constants for the field tokenizer
// Character codes, event codes, parser state and result records.
// ----------------------------------------------------------------------------
package bft_pkg;

    // brace depth counter width and its saturation value
    localparam int unsigned DEPTH_BITS = 8;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // event codes
    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_NAME_DONE    = 3'd1,
        EV_VALUE_DONE   = 3'd2,
        EV_COMMA_TOKEN  = 3'd3,
        EV_COMMA_END    = 3'd4,
        EV_BRACE_PUSHED = 3'd5
    } event_t;

    // parser state
    typedef struct packed {
        logic [DEPTH_BITS-1:0] brace_depth;
        logic                  in_double_quote;
        logic                  in_single_quote;
        logic                  escape_pending;
        logic                  token_empty;
        logic                  last_was_space;
        logic                  value_seen;
        logic                  field_finished;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        brace_depth:     '0,
        in_double_quote: 1'b0,
        in_single_quote: 1'b0,
        escape_pending:  1'b0,
        token_empty:     1'b1,
        last_was_space:  1'b0,
        value_seen:      1'b0,
        field_finished:  1'b0
    };

    // one result beat
    typedef struct packed {
        logic   append_valid;
        logic   [7:0] append_byte;
        event_t event_code;
    } result_t;

endpackage

/* hdl/bft_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_core: per-byte decode of the field tokenizer
// Combinational next-state and result for one input byte.
// ----------------------------------------------------------------------------
module bft_core (
    input  bft_pkg::parse_state_t state_in,
    input  logic [7:0]            char_byte,
    input  logic                  field_start,
    output bft_pkg::parse_state_t state_out,
    output bft_pkg::result_t      result
);
    import bft_pkg::*;

    parse_state_t          cur;
    parse_state_t          nxt;
    logic                  in_value;
    logic                  app;
    logic [7:0]            abyte;
    event_t                ev;
    logic [DEPTH_BITS-1:0] depth_dec;

    always_comb begin
        // start of field clears everything before the byte is handled
        cur       = field_start ? STATE_CLEAR : state_in;
        nxt       = cur;
        app       = 1'b0;
        abyte     = CH_NONE;
        ev        = EV_NONE;
        in_value  = (cur.brace_depth != '0) || cur.in_double_quote;
        depth_dec = cur.brace_depth - DEPTH_BITS'(1);

        if (!cur.field_finished) begin
            case (char_byte)
                CH_TAB, CH_SPACE: begin
                    // collapse blank runs inside a value
                    if (in_value && !cur.token_empty && !cur.last_was_space) begin
                        app   = 1'b1;
                        abyte = CH_SPACE;
                    end
                    nxt.escape_pending = 1'b0;
                end
                CH_EQUAL: begin
                    if (in_value) begin
                        app   = 1'b1;
                        abyte = char_byte;
                    end else begin
                        ev                 = EV_NAME_DONE;
                        nxt.token_empty    = 1'b1;
                        nxt.last_was_space = 1'b0;
                    end
                    nxt.escape_pending = 1'b0;
                end
                CH_BSLASH: begin
                    nxt.escape_pending = !cur.escape_pending;
                    app                = 1'b1;
                    abyte              = char_byte;
                end
                CH_DQUOTE: begin
                    if (!cur.escape_pending)
                        nxt.in_double_quote = !cur.in_double_quote;
                    app                = 1'b1;
                    abyte              = char_byte;
                    nxt.escape_pending = 1'b0;
                end
                CH_SQUOTE: begin
                    if (!cur.escape_pending)
                        nxt.in_single_quote = !cur.in_single_quote;
                    app                = 1'b1;
                    abyte              = char_byte;
                    nxt.escape_pending = 1'b0;
                end
                CH_LBRACE: begin
                    if (in_value) begin
                        app   = 1'b1;
                        abyte = char_byte;
                    end
                    // saturating depth count
                    if (cur.brace_depth != DEPTH_MAX)
                        nxt.brace_depth = cur.brace_depth + DEPTH_BITS'(1);
                    nxt.escape_pending = 1'b0;
                end
                CH_RBRACE: begin
                    if (cur.brace_depth == '0) begin
                        // entry-closing brace: hand it back, field ends
                        ev                 = EV_BRACE_PUSHED;
                        abyte              = char_byte;
                        nxt.field_finished = 1'b1;
                    end else begin
                        nxt.brace_depth = depth_dec;
                        if (depth_dec != '0 || cur.in_double_quote) begin
                            app   = 1'b1;
                            abyte = char_byte;
                        end else begin
                            ev                 = EV_VALUE_DONE;
                            nxt.value_seen     = !cur.token_empty;
                            nxt.token_empty    = 1'b1;
                            nxt.last_was_space = 1'b0;
                        end
                        nxt.escape_pending = 1'b0;
                    end
                end
                CH_COMMA: begin
                    if (!in_value) begin
                        ev = cur.value_seen ? EV_COMMA_END : EV_COMMA_TOKEN;
                        nxt.field_finished = 1'b1;
                    end else begin
                        app                = 1'b1;
                        abyte              = char_byte;
                        nxt.escape_pending = 1'b0;
                    end
                end
                CH_LF, CH_CR: begin
                    nxt.escape_pending = 1'b0;
                end
                default: begin
                    app                = 1'b1;
                    abyte              = char_byte;
                    nxt.escape_pending = 1'b0;
                end
            endcase

            // token bookkeeping on every appended byte
            if (app) begin
                nxt.token_empty    = 1'b0;
                nxt.last_was_space = (abyte == CH_SPACE);
            end
        end

        state_out           = nxt;
        result.append_valid = app;
        result.append_byte  = abyte;
        result.event_code   = ev;
    end

endmodule

/* hdl/bibtex_field_tokenizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibtex_field_tokenizer_top: byte-serial tokenizer for one bibliography field
// Splits name={value} / name="value" into token bytes and event codes.
//
//   channel | dir | tdata              | tuser
//   s_      | in  | [7:0] char_byte    | [0] field_start
//   m_      | out | [7:0] append_byte  | [0] append_valid, [3:1] event_code
//
// One beat in, one beat out. The result is registered and valid in the cycle after its input beat.
// A beat is accepted every cycle while the result register is empty or is
// being drained; the single output register is the only stall point.
// Reset clears the parser state and the output valid flag.
// ----------------------------------------------------------------------------
module bibtex_field_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tuser,   // [0] field_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] append_byte
    output logic [3:0] m_tuser    // [0] append_valid, [3:1] event_code
);
    import bft_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      result_next;
    logic         m_valid_reg;
    logic         s_beat;

    // result register drains or is empty: take a new beat
    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;

    bft_core u_core (
        .state_in    (state_reg),
        .char_byte   (s_tdata),
        .field_start (s_tuser),
        .state_out   (state_next),
        .result      (result_next)
    );

    // parser state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_beat)
                state_reg <= state_next;
            if (s_beat)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_beat)
            result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg.append_byte;
    assign m_tuser  = {result_reg.event_code, result_reg.append_valid};

    // pushed-back brace carries 0x7D and is never appended
    a_brace_pushback: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.event_code == EV_BRACE_PUSHED
        |-> result_reg.append_byte == CH_RBRACE && !result_reg.append_valid)
        else $error("brace push-back result malformed");

    // unused append byte reads zero outside the push-back case
    a_idle_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !result_reg.append_valid
        && result_reg.event_code != EV_BRACE_PUSHED
        |-> result_reg.append_byte == CH_NONE)
        else $error("append byte nonzero while not appended");

    // after the field ends, bytes without a new start give an empty result
    a_finished_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && state_reg.field_finished && !s_tuser
        |=> m_valid_reg && result_reg.event_code == EV_NONE
            && !result_reg.append_valid && $stable(state_reg))
        else $error("byte after field end changed state or result");

    // a name/value close always leaves the token empty
    a_token_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && (result_next.event_code == EV_NAME_DONE
                   || result_next.event_code == EV_VALUE_DONE)
        |=> state_reg.token_empty && !state_reg.last_was_space)
        else $error("token not closed on name or value event");

endmodule

/* test/bibtex_field_tokenizer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibtex_field_tokenizer_top_test: self-checking bench for the field tokenizer
// Feeds byte streams of whole fields (braced, quoted and bare values, nested
// and saturated braces, blank runs, escapes) plus random noise. A shadow parser
// predicts each result beat, and a checker compares the result beats in order.
// Both stream sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module bibtex_field_tokenizer_top_test;
    import bft_pkg::*;

    // Shadow parser plus a queue of predicted result beats
    class token_tracker;
        parse_state_t parse_st;
        result_t      queued_results[$];
        int           mismatch_count;

        function new();
            parse_st       = STATE_CLEAR;
            mismatch_count = 0;
        endfunction

        // Advance the shadow parser by one accepted byte; returns 0 if ignored
        function bit take_char(logic [7:0] c, logic start);
            result_t r;
            logic    in_value;
            logic    app;
            logic [7:0] ab;
            event_t  ev;
            app = 1'b0;
            ab  = CH_NONE;
            ev  = EV_NONE;
            if (start)
                parse_st = STATE_CLEAR;
            if (parse_st.field_finished) begin
                r = '{append_valid: 1'b0, append_byte: CH_NONE, event_code: EV_NONE};
                queued_results.push_back(r);
                return 1'b0;
            end
            in_value = (parse_st.brace_depth != 0) || parse_st.in_double_quote;
            case (c)
                CH_TAB, CH_SPACE: begin
                    // blanks collapse, never lead a token, only count inside values
                    if (in_value && !parse_st.token_empty && !parse_st.last_was_space) begin
                        app = 1'b1;
                        ab  = CH_SPACE;
                    end
                    parse_st.escape_pending = 1'b0;
                end
                CH_EQUAL: begin
                    if (in_value) begin
                        app = 1'b1;
                        ab  = c;
                    end else begin
                        ev = EV_NAME_DONE;
                        parse_st.token_empty    = 1'b1;
                        parse_st.last_was_space = 1'b0;
                    end
                    parse_st.escape_pending = 1'b0;
                end
                CH_BSLASH: begin
                    parse_st.escape_pending = !parse_st.escape_pending;
                    app = 1'b1;
                    ab  = c;
                end
                CH_DQUOTE: begin
                    if (!parse_st.escape_pending)
                        parse_st.in_double_quote = !parse_st.in_double_quote;
                    app = 1'b1;
                    ab  = c;
                    parse_st.escape_pending = 1'b0;
                end
                CH_SQUOTE: begin
                    if (!parse_st.escape_pending)
                        parse_st.in_single_quote = !parse_st.in_single_quote;
                    app = 1'b1;
                    ab  = c;
                    parse_st.escape_pending = 1'b0;
                end
                CH_LBRACE: begin
                    if (in_value) begin
                        app = 1'b1;
                        ab  = c;
                    end
                    if (parse_st.brace_depth < DEPTH_MAX)
                        parse_st.brace_depth = parse_st.brace_depth + 1'b1;
                    parse_st.escape_pending = 1'b0;
                end
                CH_RBRACE: begin
                    if (parse_st.brace_depth == 0) begin
                        // entry-closing brace: handed back, field ends
                        ev = EV_BRACE_PUSHED;
                        ab = c;
                        parse_st.field_finished = 1'b1;
                    end else begin
                        parse_st.brace_depth = parse_st.brace_depth - 1'b1;
                        if (parse_st.brace_depth != 0 || parse_st.in_double_quote) begin
                            app = 1'b1;
                            ab  = c;
                        end else begin
                            ev = EV_VALUE_DONE;
                            parse_st.value_seen     = !parse_st.token_empty;
                            parse_st.token_empty    = 1'b1;
                            parse_st.last_was_space = 1'b0;
                        end
                        parse_st.escape_pending = 1'b0;
                    end
                end
                CH_COMMA: begin
                    if (!in_value) begin
                        ev = parse_st.value_seen ? EV_COMMA_END : EV_COMMA_TOKEN;
                        parse_st.field_finished = 1'b1;
                    end else begin
                        app = 1'b1;
                        ab  = c;
                        parse_st.escape_pending = 1'b0;
                    end
                end
                CH_LF, CH_CR: begin
                    parse_st.escape_pending = 1'b0;
                end
                default: begin
                    app = 1'b1;
                    ab  = c;
                    parse_st.escape_pending = 1'b0;
                end
            endcase
            if (app) begin
                parse_st.token_empty    = 1'b0;
                parse_st.last_was_space = (ab == CH_SPACE);
            end
            r = '{append_valid: app, append_byte: ab, event_code: ev};
            queued_results.push_back(r);
            return 1'b1;
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        // Compare one accepted result beat with the oldest prediction
        task match_result(logic av, logic [7:0] ab, logic [2:0] ev);
            result_t want;
            if (queued_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat av=%0b byte=%02h ev=%0d",
                                        av, ab, ev));
                return;
            end
            want = queued_results.pop_front();
            if (av !== want.append_valid)
                flag_mismatch($sformatf("append_valid got %0b want %0b",
                                        av, want.append_valid));
            if (ab !== want.append_byte)
                flag_mismatch($sformatf("append_byte got %02h want %02h",
                                        ab, want.append_byte));
            if (ev !== want.event_code)
                flag_mismatch($sformatf("event_code got %0d want %0d",
                                        ev, want.event_code));
        endtask

        function int pending();
            return queued_results.size();
        endfunction
    endclass

    localparam int STALL_LIMIT  = 1000;
    localparam int TARGET_BYTES = 1350;
    localparam int QUIET_FROM   = 1200;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;

    token_tracker tracker = new();
    bit           idle_on;
    int           parsed_bytes;
    int           stall_left = 0;
    int           quiet_cycles = 0;

    bibtex_field_tokenizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random stall bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result(m_tuser[0], m_tdata, m_tuser[3:1]);
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL bibtex_field_tokenizer_top");
                $finish;
            end
        end
    end

    // Drive one input beat; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic start);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        if (tracker.take_char(c, start))
            parsed_bytes++;
        @(negedge aclk);
    endtask

    // Random byte that has no special meaning to the parser
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_DQUOTE, CH_SQUOTE,
                         CH_COMMA, CH_EQUAL, CH_BSLASH, CH_LBRACE, CH_RBRACE});
        return b;
    endfunction

    // Value body with blanks, escapes, quotes and balanced nested braces
    task automatic send_body(input int len, input bit quoted);
        int open;
        int k;
        int n;
        open = 0;
        for (int i = 0; i < len; i++) begin
            k = $urandom_range(0, 15);
            case (k)
                8: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
                end
                9:  send_char($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
                10: begin
                    send_char(CH_BSLASH, 1'b0);
                    if (quoted)
                        send_char(CH_DQUOTE, 1'b0);
                    else
                        send_char($urandom_range(0, 1) ? CH_SQUOTE : CH_BSLASH, 1'b0);
                end
                11: send_char(CH_SQUOTE, 1'b0);
                12: send_char($urandom_range(0, 1) ? CH_EQUAL : CH_COMMA, 1'b0);
                13: begin
                    send_char(CH_LBRACE, 1'b0);
                    open++;
                end
                14: begin
                    if (open > 0) begin
                        send_char(CH_RBRACE, 1'b0);
                        open--;
                    end else begin
                        send_char(pick_plain(), 1'b0);
                    end
                end
                15: begin
                    // stray double quote inside a braced value, rarely
                    if (!quoted && $urandom_range(0, 3) == 0)
                        send_char(CH_DQUOTE, 1'b0);
                    else
                        send_char(pick_plain(), 1'b0);
                end
                default: send_char(pick_plain(), 1'b0);
            endcase
        end
        while (open > 0) begin
            send_char(CH_RBRACE, 1'b0);
            open--;
        end
    endtask

    // One field: name, usually '=', a braced, quoted or bare value, usually a terminator, then up to two random bytes
    task automatic send_field();
        int nlen;
        int style;
        int tail;
        int extra;
        nlen = $urandom_range(1, 6);
        send_char(($urandom_range(0, 4) == 0) ? CH_SPACE : pick_plain(), 1'b1);
        for (int i = 1; i < nlen; i++)
            send_char(($urandom_range(0, 7) == 0) ? CH_SPACE : pick_plain(), 1'b0);
        if ($urandom_range(0, 9) != 0)
            send_char(CH_EQUAL, 1'b0);
        if ($urandom_range(0, 2) == 0)
            send_char(CH_SPACE, 1'b0);
        style = $urandom_range(0, 9);
        if (style < 6) begin
            send_char(CH_LBRACE, 1'b0);
            send_body($urandom_range(0, 10), 1'b0);
            send_char(CH_RBRACE, 1'b0);
        end else if (style < 9) begin
            send_char(CH_DQUOTE, 1'b0);
            send_body($urandom_range(0, 10), 1'b1);
            send_char(CH_DQUOTE, 1'b0);
        end else begin
            repeat ($urandom_range(0, 4)) send_char(pick_plain(), 1'b0);
        end
        tail = $urandom_range(0, 9);
        if (tail < 7)
            send_char(CH_COMMA, 1'b0);
        else if (tail < 9)
            send_char(CH_RBRACE, 1'b0);
        extra = $urandom_range(0, 2);
        repeat (extra) send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Nesting past the counter's maximum, then unwinding to value done
    task automatic send_deep_field();
        send_char("d", 1'b1);
        send_char(CH_EQUAL, 1'b0);
        repeat (int'(DEPTH_MAX) + 5) send_char(CH_LBRACE, 1'b0);
        repeat (int'(DEPTH_MAX)) send_char(CH_RBRACE, 1'b0);
        send_char(CH_COMMA, 1'b0);
    endtask

    initial begin
        bit deep_done;
        int pick;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = 1'b0;
        idle_on      = 1'b0;
        parsed_bytes = 0;
        deep_done    = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: name/value events, blank collapse, escapes, inner specials
        send_char("n", 1'b1);
        send_char(CH_EQUAL, 1'b0);
        send_char(CH_LBRACE, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char("a", 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_DQUOTE, 1'b0);
        send_char(CH_SQUOTE, 1'b0);
        send_char(CH_EQUAL, 1'b0);
        send_char(CH_COMMA, 1'b0);
        send_char(CH_LBRACE, 1'b0);
        send_char(CH_RBRACE, 1'b0);
        send_char(CH_RBRACE, 1'b0);
        send_char(CH_COMMA, 1'b0);
        // bytes after the end are ignored
        send_char("x", 1'b0);
        // entry-closing brace at depth zero is handed back
        send_char(CH_RBRACE, 1'b1);
        // comma with nothing seen takes the token as value
        send_char(CH_COMMA, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        // quoted value ends with comma only
        send_char("t", 1'b1);
        send_char(CH_EQUAL, 1'b0);
        send_char(CH_DQUOTE, 1'b0);
        send_char("q", 1'b0);
        send_char(CH_DQUOTE, 1'b0);
        send_char(CH_COMMA, 1'b0);

        // Random: mostly well-formed fields, some noise, one deep nesting
        while (parsed_bytes < TARGET_BYTES) begin
            if (parsed_bytes >= QUIET_FROM)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (!deep_done && parsed_bytes > 300) begin
                send_deep_field();
                deep_done = 1'b1;
            end else if (pick < 16) begin
                send_field();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("PASS bibtex_field_tokenizer_top");
        else
            $display("FAIL bibtex_field_tokenizer_top");
        $finish;
    end

endmodule
